// ----- design/per_client_window_rate_limiter_core_defines.svh -----
`ifndef PER_CLIENT_WINDOW_RATE_LIMITER_CORE_DEFINES_SVH
`define PER_CLIENT_WINDOW_RATE_LIMITER_CORE_DEFINES_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define PCWRL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define PCWRL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/pcwrl_pkg.sv -----
`default_nettype none

package pcwrl_pkg;

    // Table and field sizes.
    localparam int CLIENT_SLOTS = 256;
    localparam int SLOT_W       = $clog2(CLIENT_SLOTS);
    localparam int TIME_W       = 32;
    localparam int COUNT_W      = 17;
    localparam int LIMIT_W      = 16;

    localparam logic [LIMIT_W-1:0] DEFAULT_WINDOW = 16'd300;
    localparam logic [COUNT_W-1:0] COUNT_MAX      = 17'h1FFFF;
    localparam logic [LIMIT_W-1:0] RETRY_MAX      = 16'hFFFF;

    // Configuration register indexes and reset values.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_REQ_QUOTA     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_SECONDS = 1'b1;
    localparam logic [LIMIT_W-1:0] RST_REQ_QUOTA     = 16'd100;
    localparam logic [LIMIT_W-1:0] RST_LIMIT_SECONDS = 16'd300;

    // Queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef logic [SLOT_W-1:0] t_slot;

    typedef struct packed {
        logic [7:0]        client_slot;
        logic [TIME_W-1:0] now_secs;
    } t_req;

    typedef struct packed {
        logic               refused;
        logic [LIMIT_W-1:0] wait_secs;
    } t_resp;

    typedef struct packed {
        t_slot             slot;
        logic [TIME_W-1:0] now_secs;
    } t_job;

    typedef struct packed {
        logic [LIMIT_W-1:0] req_quota;
        logic [LIMIT_W-1:0] limit_seconds;
    } t_cfg;

    typedef struct packed {
        logic               locked;
        logic [TIME_W-1:0]  window_begin;
        logic [COUNT_W-1:0] hit_count;
        logic [TIME_W-1:0]  lock_until;
        logic [LIMIT_W-1:0] entry_limit;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

`default_nettype wire

// ----- design/pcwrl_ram.sv -----
`default_nettype none

module pcwrl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // One write port and one read port with registered read data.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ----- design/pcwrl_front.sv -----
`default_nettype none

`include "per_client_window_rate_limiter_core_defines.svh"

module pcwrl_front
    import pcwrl_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_req i_in_req,
    output logic      o_job_valid,
    input  wire logic i_job_ready,
    output t_job      o_job
);

    t_job                r_queue [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_AW:0]   r_count;
    logic                push;
    logic                pop;
    t_job                job_in;

    // The slot index is reduced to the table size before it is queued.
    always_comb begin
        job_in.slot     = i_in_req.client_slot[SLOT_W-1:0];
        job_in.now_secs = i_in_req.now_secs;
    end

    assign o_in_ready  = (r_count != (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_job_valid = (r_count != '0);
    assign o_job       = r_queue[r_rd_ptr];
    assign push        = i_in_valid && o_in_ready;
    assign pop         = o_job_valid && i_job_ready;

    // Queue storage holds payload only.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_queue[r_wr_ptr] <= job_in;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `PCWRL_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1,
        r_count <= (QUEUE_AW+1)'(QUEUE_DEPTH), "queue fill level beyond depth")
    `PCWRL_ASSERT_NEXT(a_push_grows, i_clk, i_rst_n, push && !pop,
        r_count == $past(r_count) + 1'b1, "queue level did not grow on push")
    `PCWRL_ASSERT_NOW(a_pop_not_empty, i_clk, i_rst_n, pop,
        r_count != '0, "item taken from an empty queue")

endmodule

`default_nettype wire

// ----- design/pcwrl_back.sv -----
`default_nettype none

`include "per_client_window_rate_limiter_core_defines.svh"

module pcwrl_back
    import pcwrl_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_cfg  i_cfg,
    input  wire logic  i_job_valid,
    output logic       o_job_ready,
    input  wire t_job  i_job,
    output logic       o_out_valid,
    input  wire logic  i_out_ready,
    output t_resp      o_out_resp
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_READ   = 2'd1;
    localparam logic [1:0] ST_COMMIT = 2'd2;

    logic [1:0]          r_state;
    logic [1:0]          n_state;
    t_job                r_job;
    logic                r_hit_valid;
    logic [CLIENT_SLOTS-1:0] r_valid_bits;

    t_entry              r_entry;
    logic                r_cool_done;
    logic                r_win_passed;
    logic [LIMIT_W-1:0]  r_left;

    logic                r_out_valid;
    t_resp               r_out_resp;

    logic [ENTRY_W-1:0]  ram_rdata;
    t_entry              rd_entry;
    logic                issue;
    logic                commit;
    logic                out_free;

    logic [TIME_W-1:0]   since;
    logic [TIME_W-1:0]   left_full;
    logic [TIME_W-1:0]   win_diff;
    logic [TIME_W-1:0]   window_len;

    logic [COUNT_W-1:0]  next_count;
    logic [LIMIT_W-1:0]  next_limit;
    t_entry              new_entry;
    t_resp               new_resp;

    // Entry table, one row per client slot.
    pcwrl_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CLIENT_SLOTS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (commit),
        .i_waddr (r_job.slot),
        .i_wdata (new_entry),
        .i_re    (issue),
        .i_raddr (i_job.slot),
        .o_rdata (ram_rdata)
    );

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_job_ready = (r_state == ST_IDLE);
    assign issue       = i_job_valid && o_job_ready;
    assign commit      = (r_state == ST_COMMIT) && out_free;

    // A slot never written since reset reads as all zero.
    assign rd_entry = r_hit_valid ? t_entry'(ram_rdata) : '0;

    // First half: the three time differences and the window length.
    always_comb begin
        since      = r_job.now_secs - rd_entry.lock_until;
        left_full  = rd_entry.lock_until - r_job.now_secs;
        win_diff   = r_job.now_secs - rd_entry.window_begin;
        window_len = (i_cfg.limit_seconds != '0)
                   ? {{(TIME_W-LIMIT_W){1'b0}}, i_cfg.limit_seconds}
                   : {{(TIME_W-LIMIT_W){1'b0}}, DEFAULT_WINDOW};
    end

    // Second half: new entry contents and the decision.
    always_comb begin
        new_entry  = r_entry;
        new_resp   = '0;
        next_count = r_entry.hit_count;
        next_limit = r_entry.entry_limit;
        if (r_entry.locked) begin
            if (r_cool_done) begin
                // Cooldown over: the entry restarts and this item is allowed.
                new_entry.locked       = 1'b0;
                new_entry.hit_count    = COUNT_W'(1);
                new_entry.window_begin = r_job.now_secs;
                new_entry.entry_limit  = i_cfg.req_quota;
            end else begin
                new_resp.refused   = 1'b1;
                new_resp.wait_secs = r_left;
            end
        end else begin
            if (r_win_passed) begin
                next_count             = COUNT_W'(1);
                new_entry.window_begin = r_job.now_secs;
            end else if (r_entry.hit_count < COUNT_MAX) begin
                next_count = r_entry.hit_count + COUNT_W'(1);
            end
            if (r_entry.entry_limit == '0) begin
                next_limit = i_cfg.req_quota;
            end
            new_entry.hit_count   = next_count;
            new_entry.entry_limit = next_limit;
            if (next_count > {1'b0, next_limit}) begin
                new_entry.locked     = 1'b1;
                new_entry.lock_until = r_job.now_secs
                                     + {{(TIME_W-LIMIT_W){1'b0}}, i_cfg.limit_seconds};
                new_resp.refused     = 1'b1;
                new_resp.wait_secs   = i_cfg.limit_seconds;
            end
        end
    end

    // Sequencer: take an item, read its row, evaluate, write back.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (issue) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                n_state = ST_COMMIT;
            end
            ST_COMMIT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Payload registers of the item under way.
    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_job       <= i_job;
            r_hit_valid <= r_valid_bits[i_job.slot];
        end
        if (r_state == ST_READ) begin
            r_entry      <= rd_entry;
            r_cool_done  <= !since[TIME_W-1];
            r_win_passed <= (win_diff >= window_len);
            r_left       <= (left_full[TIME_W-1:LIMIT_W] != '0)
                          ? RETRY_MAX : left_full[LIMIT_W-1:0];
        end
        if (commit) begin
            r_out_resp <= new_resp;
        end
    end

    // Control state, valid bits and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_valid_bits <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (commit) begin
                r_valid_bits[r_job.slot] <= 1'b1;
                r_out_valid              <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_resp  = r_out_resp;

    `PCWRL_ASSERT_NOW(a_read_after_pop, i_clk, i_rst_n, r_state == ST_READ,
        $past(i_job_valid && o_job_ready), "row read without a popped item")
    `PCWRL_ASSERT_NEXT(a_commit_shows, i_clk, i_rst_n, commit,
        r_out_valid, "committed item not presented")
    `PCWRL_ASSERT_NOW(a_allowed_zero, i_clk, i_rst_n, r_out_valid && !r_out_resp.refused,
        r_out_resp.wait_secs == '0, "allowed item carries a retry time")

endmodule

`default_nettype wire

// ----- design/per_client_window_rate_limiter_core.sv -----
// An item accepted into the queue is taken in IDLE, its row is read in READ, and in COMMIT
// it is written back and reaches the output register. The back takes a new item only after
// the write-back of the last one; a 4-item queue lets the input run ahead of the table.
// Reset is synchronous and active low: it empties the queue and the output register, sets
// the request quota to 100 and limit_seconds to 300, and marks every client entry as all zero.
`default_nettype none

module per_client_window_rate_limiter_core
    import pcwrl_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire t_req                 i_in_req,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output t_resp                     o_out_resp,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [LIMIT_W-1:0]   i_cfg_data
);

    t_cfg r_cfg;
    logic job_valid;
    logic job_ready;
    t_job job;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.req_quota     <= RST_REQ_QUOTA;
            r_cfg.limit_seconds <= RST_LIMIT_SECONDS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_REQ_QUOTA:     r_cfg.req_quota     <= i_cfg_data;
                CFG_LIMIT_SECONDS: r_cfg.limit_seconds <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Front: accepts items and queues them.
    pcwrl_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_req    (i_in_req),
        .o_job_valid (job_valid),
        .i_job_ready (job_ready),
        .o_job       (job)
    );

    // Back: updates the client table and produces the decision.
    pcwrl_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_job_valid (job_valid),
        .o_job_ready (job_ready),
        .i_job       (job),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_resp  (o_out_resp)
    );

endmodule

`default_nettype wire
